// ----- hdl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every rising clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Checks that a trigger is followed, in the next cycle, by a consequence.
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/miad_pkg.sv -----
`timescale 1ns / 1ps

package miad_pkg;

	// Lanes the block is built for, and the lanes that reach the fields
	localparam int NUM_INPUTS = 8;
	localparam int FIELD_W    = 8;
	localparam int LANES      = (NUM_INPUTS < FIELD_W) ? NUM_INPUTS : FIELD_W;

	// Field and register widths
	localparam int PERIOD_W = 16;
	localparam int MS_W     = 16;
	localparam int ACT_W    = 4;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 2;

	// Thresholds are ms * 1000, at most 65535000, which fits in 26 bits.
	// A counter never passes threshold + one period, so it fits in 26 bits too.
	localparam int US_PER_MS = 1000;
	localparam int THR_W     = 26;
	localparam int CNT_W     = 26;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE_HIGH_MS = 2'd0,
		REG_DEBOUNCE_LOW_MS  = 2'd1,
		REG_ACTIVE_INPUTS    = 2'd2
	} reg_idx_t;

	// Decoded configuration shared by every lane
	typedef struct packed {
		logic [THR_W-1:0] thr_hi;
		logic [THR_W-1:0] thr_lo;
		logic [ACT_W-1:0] active_inputs;
	} cfg_t;

	// Next level and edge flags of one lane for the current tick
	typedef struct packed {
		logic level;
		logic rise;
		logic fall;
	} lane_res_t;

endpackage

// ----- hdl/miad_cfg.sv -----
`timescale 1ns / 1ps

module miad_cfg
	import miad_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	output cfg_t             cfg
);

	logic [THR_W-1:0] thr_hi_q;
	logic [THR_W-1:0] thr_lo_q;
	logic [ACT_W-1:0] active_q;
	logic [THR_W-1:0] thr_wr;

	// Threshold in microseconds, converted once at write time
	assign thr_wr = THR_W'(cfg_wdata[MS_W-1:0]) * THR_W'(US_PER_MS);

	// Register file; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_hi_q <= '0;
			thr_lo_q <= '0;
			active_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE_HIGH_MS: thr_hi_q <= thr_wr;
				REG_DEBOUNCE_LOW_MS:  thr_lo_q <= thr_wr;
				REG_ACTIVE_INPUTS:    active_q <= cfg_wdata[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.thr_hi        = thr_hi_q;
	assign cfg.thr_lo        = thr_lo_q;
	assign cfg.active_inputs = active_q;

endmodule

// ----- hdl/miad_lane.sv -----
`timescale 1ns / 1ps

module miad_lane
	import miad_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  logic                act,
	input  logic                raw,
	input  logic [PERIOD_W-1:0] period,
	input  cfg_t                cfg,
	output lane_res_t           res
);

	logic             lvl_q;
	logic [CNT_W-1:0] rise_q;
	logic [CNT_W-1:0] fall_q;

	logic             lvl_d;
	logic [CNT_W-1:0] rise_d;
	logic [CNT_W-1:0] fall_d;
	logic [CNT_W:0]   rise_sum;
	logic [CNT_W:0]   fall_sum;
	logic [CNT_W-1:0] rise_sat;
	logic [CNT_W-1:0] fall_sat;
	logic             rise_flag;
	logic             fall_flag;

	// Saturating accumulate of the tick period
	assign rise_sum = {1'b0, rise_q} + (CNT_W+1)'(period);
	assign fall_sum = {1'b0, fall_q} + (CNT_W+1)'(period);
	assign rise_sat = rise_sum[CNT_W] ? '1 : rise_sum[CNT_W-1:0];
	assign fall_sat = fall_sum[CNT_W] ? '1 : fall_sum[CNT_W-1:0];

	// Next state of the lane for this tick
	always_comb begin
		lvl_d     = lvl_q;
		rise_d    = rise_q;
		fall_d    = fall_q;
		rise_flag = 1'b0;
		fall_flag = 1'b0;
		if (act) begin
			if (raw && !lvl_q) begin
				rise_d = rise_sat;
				if (rise_sat >= cfg.thr_hi) begin
					fall_d    = '0;
					lvl_d     = 1'b1;
					rise_flag = 1'b1;
				end
			end else if (!raw && lvl_q) begin
				fall_d = fall_sat;
				if (fall_sat >= cfg.thr_lo) begin
					rise_d    = '0;
					lvl_d     = 1'b0;
					fall_flag = 1'b1;
				end
			end else begin
				rise_d = '0;
				fall_d = '0;
			end
		end
	end

	// Lane state commits when the tick moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q  <= 1'b0;
			rise_q <= '0;
			fall_q <= '0;
		end else if (upd) begin
			lvl_q  <= lvl_d;
			rise_q <= rise_d;
			fall_q <= fall_d;
		end
	end

	assign res.level = lvl_d;
	assign res.rise  = rise_flag;
	assign res.fall  = fall_flag;

endmodule

// ----- hdl/multi_input_asymmetric_debouncer_unit.sv -----
`timescale 1ns / 1ps

// Debounces up to eight switch inputs against a shared pair of rise and fall
// times given in milliseconds. Each request is one timer tick carrying the
// microseconds since the last tick and the raw pin levels; each produces
// exactly one result with the filtered levels and the edges seen on that tick.
// A request passes the input register, then the result register. A new tick is
// taken every cycle unless a full result register is held by a low out_ready; every
// lane updates its counters with one add and compare per cycle. Thresholds are
// converted to microseconds when written, so configuration takes effect next cycle.
module multi_input_asymmetric_debouncer_unit
	import miad_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PERIOD_W-1:0] tick_us,
	input  logic [FIELD_W-1:0]  raw_levels,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [FIELD_W-1:0]  filtered_levels,
	output logic [FIELD_W-1:0]  rising_edges,
	output logic [FIELD_W-1:0]  falling_edges
);

	cfg_t cfg;

	logic                valid_s1;
	logic [PERIOD_W-1:0] period_s1;
	logic [FIELD_W-1:0]  raw_s1;
	logic                adv_s1;

	logic                valid_s2;
	logic [FIELD_W-1:0]  filtered_s2;
	logic [FIELD_W-1:0]  rise_s2;
	logic [FIELD_W-1:0]  fall_s2;

	logic [LANES-1:0]    lane_act;
	lane_res_t           lane_res [LANES];
	logic [FIELD_W-1:0]  filt_nxt;
	logic [FIELD_W-1:0]  rise_nxt;
	logic [FIELD_W-1:0]  fall_nxt;

	miad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake: stage 1 moves on when the result register is free or drains
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			period_s1 <= tick_us;
			raw_s1    <= raw_levels;
		end
	end

	// One cell per lane
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		assign lane_act[i] = (cfg.active_inputs > ACT_W'(i));

		miad_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (adv_s1),
			.act    (lane_act[i]),
			.raw    (raw_s1[i]),
			.period (period_s1),
			.cfg    (cfg),
			.res    (lane_res[i])
		);
	end

	// Gather lane results; lanes with no cell read as low
	always_comb begin
		filt_nxt = '0;
		rise_nxt = '0;
		fall_nxt = '0;
		for (int i = 0; i < LANES; i++) begin
			filt_nxt[i] = lane_res[i].level;
			rise_nxt[i] = lane_res[i].rise;
			fall_nxt[i] = lane_res[i].fall;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			filtered_s2 <= filt_nxt;
			rise_s2     <= rise_nxt;
			fall_s2     <= fall_nxt;
		end
	end

	assign out_valid       = valid_s2;
	assign filtered_levels = filtered_s2;
	assign rising_edges    = rise_s2;
	assign falling_edges   = fall_s2;

endmodule

// ----- hdl/miad_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module miad_checker
	import miad_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [FIELD_W-1:0] filtered_levels,
	input logic [FIELD_W-1:0] rising_edges,
	input logic [FIELD_W-1:0] falling_edges
);

	// A stalled result holds
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered_levels) && $stable(rising_edges) && $stable(falling_edges), "result changed while stalled")

	// A lane cannot rise and fall on the same tick
	`ASSERT_ALWAYS(a_edge_excl, !out_valid || ((rising_edges & falling_edges) == '0), "rise and fall on one lane")

	// A rising edge leaves the lane high
	`ASSERT_ALWAYS(a_rise_high, !out_valid || ((rising_edges & ~filtered_levels) == '0), "rising edge on a low lane")

	// A falling edge leaves the lane low
	`ASSERT_ALWAYS(a_fall_low, !out_valid || ((falling_edges & filtered_levels) == '0), "falling edge on a high lane")

endmodule

bind multi_input_asymmetric_debouncer_unit miad_checker u_miad_checker (.*);
